FILE: sv/wblc_pkg.sv
// Shared widths, codes and register reset values of the waste bin lid controller.
// No dependencies; the interfaces and the core take names from here by scope.
package wblc_pkg;

  // Field widths
  localparam int unsigned EchoW   = 16;
  localparam int unsigned ScaleW  = 16;
  localparam int unsigned FillW   = 11;
  localparam int unsigned StateW  = 3;
  localparam int unsigned LidW    = 2;
  localparam int unsigned LimitW  = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  // Default width of the saturating tick timers
  localparam int unsigned TICK_COUNT_BITS_DEF = 24;

  // Full bin in Q10
  localparam logic [FillW-1:0] FILL_ONE = 11'd1024;

  // Lid position codes
  localparam logic [LidW-1:0] LID_CLOSED = 2'd0;
  localparam logic [LidW-1:0] LID_OPEN   = 2'd1;
  localparam logic [LidW-1:0] LID_TILT   = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_EMPTY_ECHO   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FILL_SCALE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FULL_TOL     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPILL_LIMIT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SHOW_TICKS   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_EMPTY_TICKS  = 3'd6;

  // Register reset values
  localparam logic [EchoW-1:0]  RST_EMPTY_ECHO  = 16'd2915;
  localparam logic [ScaleW-1:0] RST_FILL_SCALE  = 16'd28777;
  localparam logic [FillW-1:0]  RST_THRESHOLD   = 11'd922;
  localparam logic [LimitW-1:0] RST_FULL_TOL    = 24'd3000;
  localparam logic [LimitW-1:0] RST_SPILL_LIMIT = 24'd10000;
  localparam logic [LimitW-1:0] RST_SHOW_TICKS  = 24'd2000;
  localparam logic [LimitW-1:0] RST_EMPTY_TICKS = 24'd3000;

endpackage

FILE: sv/wblc_in_if.sv
// Input channel of the lid controller: one tick word per handshake.
// Depends on wblc_pkg for field widths.
interface wblc_in_if;
  logic                          valid;
  logic                          ready;
  logic [wblc_pkg::EchoW-1:0]    echo_us;
  logic                          open_button;
  logic                          close_button;
  logic                          empty_request;
  logic                          force_valid;
  logic [wblc_pkg::StateW-1:0]   force_state;

  modport source (
    output valid, echo_us, open_button, close_button, empty_request,
           force_valid, force_state,
    input  ready
  );
  modport sink (
    input  valid, echo_us, open_button, close_button, empty_request,
           force_valid, force_state,
    output ready
  );
endinterface

FILE: sv/wblc_out_if.sv
// Result channel of the lid controller: one status word per tick.
// Depends on wblc_pkg for field widths.
interface wblc_out_if;
  logic                          valid;
  logic                          ready;
  logic [wblc_pkg::FillW-1:0]    fill_level;
  logic [wblc_pkg::StateW-1:0]   ctrl_state;
  logic [wblc_pkg::LidW-1:0]     lid_position;
  logic                          alarm_on;

  modport source (
    output valid, fill_level, ctrl_state, lid_position, alarm_on,
    input  ready
  );
  modport sink (
    input  valid, fill_level, ctrl_state, lid_position, alarm_on,
    output ready
  );
endinterface

FILE: sv/waste_bin_lid_controller_core.sv
// Top level of the waste bin lid controller: input register, tick step, result register.
// Depends on wblc_pkg, wblc_in_if and wblc_out_if.
//
//   channel   direction  handshake      word
//   in_ch     sink       valid/ready    echo, buttons, empty request, state write
//   out_ch    source     valid/ready    fill level, state, lid position, alarm
//   cfg_*     sink       write enable   register index and data, no read-back
//
// One tick word per cycle while the result slot is free or being taken; a word passes the input
// register, then the fill multiply and state step into the result register.
// Reset is synchronous: registers to defaults, state available, lid closed, pipe empty.
// A stalled result holds the pipe; the input register still takes one word behind it.
module waste_bin_lid_controller_core #(
  parameter int unsigned TICK_COUNT_BITS = wblc_pkg::TICK_COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  wblc_in_if.sink                       in_ch,
  wblc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [wblc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wblc_pkg::CfgDatW-1:0]  cfg_data
);

  localparam int unsigned TW   = TICK_COUNT_BITS;
  localparam int unsigned CMPW = (TW > wblc_pkg::LimitW) ? TW : wblc_pkg::LimitW;
  localparam int unsigned DIFW = wblc_pkg::EchoW + 1;
  localparam int unsigned PRDW = wblc_pkg::EchoW + wblc_pkg::ScaleW;

  typedef enum logic [wblc_pkg::StateW-1:0] {
    ST_AVAILABLE   = 3'd0,
    ST_ACCEPTING   = 3'd1,
    ST_RECEIVED    = 3'd2,
    ST_EMPTYING    = 3'd3,
    ST_FULL        = 3'd4,
    ST_OVERHEATING = 3'd5,
    ST_SLEEPING    = 3'd6
  } mode_t;

  // Configuration registers
  logic [wblc_pkg::EchoW-1:0]  empty_echo_r;
  logic [wblc_pkg::ScaleW-1:0] fill_scale_r;
  logic [wblc_pkg::FillW-1:0]  threshold_r;
  logic [wblc_pkg::LimitW-1:0] full_tol_r;
  logic [wblc_pkg::LimitW-1:0] spill_limit_r;
  logic [wblc_pkg::LimitW-1:0] show_ticks_r;
  logic [wblc_pkg::LimitW-1:0] empty_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_echo_r  <= wblc_pkg::RST_EMPTY_ECHO;
      fill_scale_r  <= wblc_pkg::RST_FILL_SCALE;
      threshold_r   <= wblc_pkg::RST_THRESHOLD;
      full_tol_r    <= wblc_pkg::RST_FULL_TOL;
      spill_limit_r <= wblc_pkg::RST_SPILL_LIMIT;
      show_ticks_r  <= wblc_pkg::RST_SHOW_TICKS;
      empty_ticks_r <= wblc_pkg::RST_EMPTY_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wblc_pkg::CFG_EMPTY_ECHO:  empty_echo_r  <= cfg_data[wblc_pkg::EchoW-1:0];
        wblc_pkg::CFG_FILL_SCALE:  fill_scale_r  <= cfg_data[wblc_pkg::ScaleW-1:0];
        wblc_pkg::CFG_THRESHOLD:   threshold_r   <= cfg_data[wblc_pkg::FillW-1:0];
        wblc_pkg::CFG_FULL_TOL:    full_tol_r    <= cfg_data[wblc_pkg::LimitW-1:0];
        wblc_pkg::CFG_SPILL_LIMIT: spill_limit_r <= cfg_data[wblc_pkg::LimitW-1:0];
        wblc_pkg::CFG_SHOW_TICKS:  show_ticks_r  <= cfg_data[wblc_pkg::LimitW-1:0];
        wblc_pkg::CFG_EMPTY_TICKS: empty_ticks_r <= cfg_data[wblc_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on when the result slot is free or being taken
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // Input register
  logic [wblc_pkg::EchoW-1:0]  s1_echo_r;
  logic                        s1_open_r;
  logic                        s1_close_r;
  logic                        s1_empty_req_r;
  logic                        s1_force_v_r;
  logic [wblc_pkg::StateW-1:0] s1_force_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_echo_r      <= in_ch.echo_us;
      s1_open_r      <= in_ch.open_button;
      s1_close_r     <= in_ch.close_button;
      s1_empty_req_r <= in_ch.empty_request;
      s1_force_v_r   <= in_ch.force_valid;
      s1_force_s_r   <= in_ch.force_state;
    end
  end

  // Fill level: difference, Q16 scale, clamp to zero and one
  logic [DIFW-1:0]              diff;
  logic [PRDW-1:0]              prod;
  logic [wblc_pkg::EchoW-1:0]   prod_hi;
  logic [wblc_pkg::FillW-1:0]   fill;

  assign diff    = {1'b0, empty_echo_r} - {1'b0, s1_echo_r};
  assign prod    = diff[wblc_pkg::EchoW-1:0] * fill_scale_r;
  assign prod_hi = prod[PRDW-1:wblc_pkg::ScaleW];

  always_comb begin
    if (diff[DIFW-1]) begin
      fill = '0;
    end else if (prod_hi > wblc_pkg::EchoW'(wblc_pkg::FILL_ONE)) begin
      fill = wblc_pkg::FILL_ONE;
    end else begin
      fill = prod_hi[wblc_pkg::FillW-1:0];
    end
  end

  // Controller state
  mode_t                       mode_r, mode_nxt, mode_in;
  logic [TW-1:0]               full_tmr_r, full_tmr_nxt, full_inc;
  logic [TW-1:0]               spill_tmr_r, spill_tmr_nxt, spill_inc;
  logic [TW-1:0]               show_tmr_r, show_tmr_nxt, show_inc;
  logic [TW-1:0]               empty_tmr_r, empty_tmr_nxt, empty_inc;
  logic                        pend_r, pend_nxt;
  logic [wblc_pkg::LidW-1:0]   lid_r, lid_nxt;
  logic                        alarm_r, alarm_nxt;
  logic [wblc_pkg::FillW-1:0]  out_fill_r;
  logic                        full_due;

  // Saturating count-up of the tick timers
  assign full_inc  = (full_tmr_r  == '1) ? full_tmr_r  : full_tmr_r  + 1'b1;
  assign spill_inc = (spill_tmr_r == '1) ? spill_tmr_r : spill_tmr_r + 1'b1;
  assign show_inc  = (show_tmr_r  == '1) ? show_tmr_r  : show_tmr_r  + 1'b1;
  assign empty_inc = (empty_tmr_r == '1) ? empty_tmr_r : empty_tmr_r + 1'b1;

  // Take the external state write; code seven leaves the mode alone
  always_comb begin
    mode_in = mode_r;
    if (s1_force_v_r && s1_force_s_r <= ST_SLEEPING) begin
      mode_in = mode_t'(s1_force_s_r);
    end
  end

  assign full_due = (CMPW'(full_inc) >= CMPW'(full_tol_r)) && (fill > threshold_r);

  // One tick of the lid controller
  always_comb begin
    mode_nxt      = mode_in;
    full_tmr_nxt  = full_inc;
    spill_tmr_nxt = spill_inc;
    show_tmr_nxt  = show_inc;
    empty_tmr_nxt = empty_inc;
    pend_nxt      = pend_r || s1_empty_req_r;
    lid_nxt       = lid_r;
    alarm_nxt     = alarm_r;

    unique case (mode_in)
      ST_AVAILABLE: begin
        if (s1_open_r) begin
          lid_nxt       = wblc_pkg::LID_OPEN;
          spill_tmr_nxt = '0;
          mode_nxt      = ST_ACCEPTING;
        end else if (full_due) begin
          mode_nxt = ST_FULL;
        end
      end
      ST_ACCEPTING: begin
        if (s1_close_r || (CMPW'(spill_inc) >= CMPW'(spill_limit_r))) begin
          lid_nxt      = wblc_pkg::LID_CLOSED;
          show_tmr_nxt = '0;
          mode_nxt     = ST_RECEIVED;
        end else if (full_due) begin
          mode_nxt = ST_FULL;
        end
      end
      ST_RECEIVED: begin
        if (CMPW'(show_inc) >= CMPW'(show_ticks_r)) begin
          mode_nxt = ST_AVAILABLE;
        end
      end
      ST_EMPTYING: begin
        if (CMPW'(empty_inc) >= CMPW'(empty_ticks_r)) begin
          lid_nxt  = wblc_pkg::LID_CLOSED;
          mode_nxt = ST_AVAILABLE;
        end
      end
      ST_FULL: begin
        if (pend_nxt) begin
          lid_nxt       = wblc_pkg::LID_TILT;
          mode_nxt      = ST_EMPTYING;
          pend_nxt      = 1'b0;
          empty_tmr_nxt = '0;
        end
      end
      default: ;
    endcase

    // Restart the full timer while the bin is below the threshold
    if (fill < threshold_r) begin
      full_tmr_nxt = '0;
    end

    // Lamp and lid actions of the state reached
    case (mode_nxt)
      ST_AVAILABLE, ST_ACCEPTING, ST_RECEIVED: begin
        alarm_nxt = 1'b0;
      end
      ST_FULL, ST_OVERHEATING: begin
        alarm_nxt = 1'b1;
        lid_nxt   = wblc_pkg::LID_CLOSED;
      end
      default: ;
    endcase
  end

  // State and result register; state doubles as the held result fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ST_AVAILABLE;
      full_tmr_r  <= '0;
      spill_tmr_r <= '0;
      show_tmr_r  <= '0;
      empty_tmr_r <= '0;
      pend_r      <= 1'b0;
      lid_r       <= wblc_pkg::LID_CLOSED;
      alarm_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        mode_r      <= mode_nxt;
        full_tmr_r  <= full_tmr_nxt;
        spill_tmr_r <= spill_tmr_nxt;
        show_tmr_r  <= show_tmr_nxt;
        empty_tmr_r <= empty_tmr_nxt;
        pend_r      <= pend_nxt;
        lid_r       <= lid_nxt;
        alarm_r     <= alarm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_fill_r <= fill;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.fill_level   = out_fill_r;
  assign out_ch.ctrl_state   = mode_r;
  assign out_ch.lid_position = lid_r;
  assign out_ch.alarm_on     = alarm_r;

`ifndef NO_ASSERTIONS
  // Full and overheating always show the alarm lamp with the lid shut
  a_full_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (mode_r == ST_FULL || mode_r == ST_OVERHEATING))
      |-> (alarm_r && lid_r == wblc_pkg::LID_CLOSED))
    else $error("full or overheating without alarm and closed lid");

  // Fill never exceeds one
  a_fill_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fill_r <= wblc_pkg::FILL_ONE))
    else $error("fill level above one");

  // A word in the input register reaches the result slot when it moves
  a_word_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> out_valid_r)
    else $error("word lost between input and result register");

  // Sleeping is left only by an external state write
  a_sleep_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == ST_SLEEPING && s1_valid_r && s1_adv && !s1_force_v_r)
      |=> (mode_r == ST_SLEEPING))
    else $error("sleeping left without a state write");
`endif

endmodule
